// ----- hdl/rdft_pkg.sv -----
// ----------------------------------------------------------------------------
// rdft_pkg
// Shared types, constants and twiddle tables for the real-input DFT/IDFT unit.
// ----------------------------------------------------------------------------
package rdft_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TW_W       = 16;
    localparam int OUT_W      = 19;
    localparam int BIN_W      = 3;
    localparam int PTS_W      = 4;
    localparam int MAX_POINTS = 8;
    localparam int Q_SHIFT    = 14;
    localparam int OUT_MAX    = 262143;
    localparam int OUT_MIN    = -262144;

    typedef enum logic {
        CFG_POINTS  = 1'b0,
        CFG_INVERSE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             bank;
        logic [PTS_W-1:0] points;
        logic             inverse;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_DRAIN,
        B_DIV,
        B_PUT
    } back_state_t;

    typedef logic signed [TW_W-1:0] twiddle_t;

    localparam twiddle_t COS_TAB [0:MAX_POINTS][0:MAX_POINTS-1] = '{
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, -16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063,
          16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192,
          16'sd8192, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761,
          -16'sd3646, 16'sd10215, 16'sd0},
        '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384,
          -16'sd11585, 16'sd0, 16'sd11585}
    };

    localparam twiddle_t SIN_TAB [0:MAX_POINTS][0:MAX_POINTS-1] = '{
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd14189, -16'sd14189, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd15582, 16'sd9630, -16'sd9630, -16'sd15582,
          16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd14189, 16'sd14189, 16'sd0, -16'sd14189,
          -16'sd14189, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd12810, 16'sd15973, 16'sd7109, -16'sd7109,
          -16'sd15973, -16'sd12810, 16'sd0},
        '{16'sd0, 16'sd11585, 16'sd16384, 16'sd11585, 16'sd0,
          -16'sd11585, -16'sd16384, -16'sd11585}
    };

endpackage

// ----- hdl/real_input_dft_idft_unit.sv -----
// ----------------------------------------------------------------------------
// real_input_dft_idft_unit
// Direct real-input DFT / IDFT over a block of SAMPLES samples.
// Samples are accepted one per cycle while a free sample bank exists; two
// banks let the next block load while the current one is transformed.
// Each bin is accumulated on the single shared MAC, then in inverse mode it
// passes through the bit-serial 1/points divide. Synchronous active-low
// reset returns points to 8, inverse to 0, empties both banks and clears
// the load count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module real_input_dft_idft_unit import rdft_pkg::*; #(
    parameter int SAMPLES = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  cfg_index_t                 cfg_index,
    input  logic [PTS_W-1:0]           cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [BIN_W-1:0]           m_bin,
    output logic signed [OUT_W-1:0]    m_real_part,
    output logic signed [OUT_W-1:0]    m_imag_part,
    output logic                       m_last
);

    localparam int AW = $clog2(SAMPLES) + 1;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic                       push_valid;
    job_t                       push_job;
    logic                       fifo_full;
    logic                       fifo_empty;
    logic                       job_pop;
    job_t                       head_job;
    release_t                   rel;

    rdft_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push_valid (push_valid),
        .push_job   (push_job),
        .rel        (rel)
    );

    rdft_job_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (job_pop),
        .empty    (fifo_empty),
        .head     (head_job)
    );

    rdft_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (!fifo_empty),
        .job_pop     (job_pop),
        .job         (head_job),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rel         (rel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin       (m_bin),
        .m_real_part (m_real_part),
        .m_imag_part (m_imag_part),
        .m_last      (m_last)
    );

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !fifo_full)
        else $error("job pushed while queue full");

endmodule

// ----- hdl/rdft_front.sv -----
// ----------------------------------------------------------------------------
// rdft_front
// Holds the configuration registers, loads samples into one of two sample
// banks and hands each full bank to the back end as a job.
// ----------------------------------------------------------------------------
module rdft_front import rdft_pkg::*; #(
    parameter int SAMPLES = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  cfg_index_t                 cfg_index,
    input  logic [PTS_W-1:0]           cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       wr_en,
    output logic [$clog2(SAMPLES):0]   wr_addr,
    output logic signed [SAMPLE_W-1:0] wr_data,
    output logic                       push_valid,
    output job_t                       push_job,
    input  release_t                   rel
);

    localparam int NW = $clog2(SAMPLES);

    logic [PTS_W-1:0] points_reg;
    logic             inverse_reg;
    logic [NW-1:0]    load_count_reg;
    logic [NW-1:0]    load_count_next;
    logic             bank_reg;
    logic [1:0]       busy_reg;
    logic [1:0]       busy_next;
    logic [PTS_W-1:0] points_eff;
    logic             accept;
    logic             block_end;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg[bank_reg];
    assign accept    = s_valid && s_ready;
    assign block_end = (load_count_reg == NW'(SAMPLES - 1));

    assign wr_en   = accept;
    assign wr_addr = {bank_reg, load_count_reg};
    assign wr_data = s_sample;

    always_comb begin
        priority if (points_reg == '0) begin
            points_eff = PTS_W'(1);
        end else if (points_reg > PTS_W'(MAX_POINTS)) begin
            points_eff = PTS_W'(MAX_POINTS);
        end else begin
            points_eff = points_reg;
        end
    end

    assign push_valid       = accept && block_end;
    assign push_job.bank    = bank_reg;
    assign push_job.points  = points_eff;
    assign push_job.inverse = inverse_reg;

    always_comb begin
        load_count_next = load_count_reg;
        if (accept) begin
            load_count_next = block_end ? '0 : load_count_reg + NW'(1);
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (push_valid) begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg  <= PTS_W'(MAX_POINTS);
            inverse_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_POINTS:  points_reg  <= cfg_data;
                CFG_INVERSE: inverse_reg <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
        end else begin
            load_count_reg <= load_count_next;
            busy_reg       <= busy_next;
            if (push_valid) begin
                bank_reg <= !bank_reg;
            end
        end
    end

endmodule

// ----- hdl/rdft_job_fifo.sv -----
// ----------------------------------------------------------------------------
// rdft_job_fifo
// Two-entry queue of pending transform jobs between front and back end.
// ----------------------------------------------------------------------------
module rdft_job_fifo import rdft_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t       entry_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> !full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("job queue read while empty");

endmodule

// ----- hdl/rdft_back.sv -----
// ----------------------------------------------------------------------------
// rdft_back
// Sample memory and shared complex MAC. For each bin it accumulates all
// samples, rounds, divides by the point count in inverse mode, saturates
// and places the result in the output register.
// ----------------------------------------------------------------------------
module rdft_back import rdft_pkg::*; #(
    parameter int SAMPLES = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    output logic                       job_pop,
    input  job_t                       job,
    input  logic                       wr_en,
    input  logic [$clog2(SAMPLES):0]   wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    output release_t                   rel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [BIN_W-1:0]           m_bin,
    output logic signed [OUT_W-1:0]    m_real_part,
    output logic signed [OUT_W-1:0]    m_imag_part,
    output logic                       m_last
);

    localparam int NW    = $clog2(SAMPLES);
    localparam int AW    = NW + 1;
    localparam int PRD_W = SAMPLE_W + TW_W;
    localparam int ACC_W = PRD_W - 1 + NW;
    localparam int T_W   = ACC_W + 1;
    localparam int Q_W   = T_W - Q_SHIFT;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(OUT_MAX);
    localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(OUT_MIN);

    logic signed [SAMPLE_W-1:0] mem [0:(2**AW)-1];

    back_state_t               state_reg;
    back_state_t               state_next;
    job_t                      job_reg;
    logic [BIN_W-1:0]          k_reg;
    logic [NW-1:0]             n_reg;
    logic [BIN_W-1:0]          m_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    twiddle_t                  tw_c_reg;
    twiddle_t                  tw_s_reg;
    logic                      s1_vld_reg;
    logic signed [PRD_W-1:0]   prod_c_reg;
    logic signed [PRD_W-1:0]   prod_s_reg;
    logic                      s2_vld_reg;
    logic signed [ACC_W-1:0]   acc_r_reg;
    logic signed [ACC_W-1:0]   acc_i_reg;
    logic [Q_W-1:0]            qr_reg;
    logic [Q_W-1:0]            qi_reg;
    logic                      neg_r_reg;
    logic                      neg_i_reg;
    logic [2:0]                rem_r_reg;
    logic [2:0]                rem_i_reg;
    logic [CNT_W-1:0]          div_cnt_reg;
    logic                      m_valid_reg;
    logic [BIN_W-1:0]          m_bin_reg;
    logic signed [OUT_W-1:0]   m_real_part_reg;
    logic signed [OUT_W-1:0]   m_imag_part_reg;
    logic                      m_last_reg;

    logic                      n_last;
    logic                      pipe_empty;
    logic                      div_done;
    logic                      out_free;
    logic                      bin_last;
    logic                      mac_issue;
    logic                      round_load;
    logic                      div_step;
    logic                      out_load;
    logic [BIN_W:0]            m_sum;
    logic [BIN_W-1:0]          m_next;
    logic signed [T_W-1:0]     half;
    logic signed [T_W-1:0]     t_r;
    logic signed [T_W-1:0]     t_i;
    logic [Q_W-1:0]            q1_r;
    logic [Q_W-1:0]            q1_i;
    logic [3:0]                r_r;
    logic [3:0]                r_i;
    logic                      ge_r;
    logic                      ge_i;
    logic signed [Q_W-1:0]     v_r;
    logic signed [Q_W-1:0]     v_i;

    function automatic logic signed [OUT_W-1:0] saturate(input logic signed [Q_W-1:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > SAT_HI) begin
            res = OUT_W'(OUT_MAX);
        end else if (v < SAT_LO) begin
            res = OUT_W'(OUT_MIN);
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

    assign n_last     = (n_reg == NW'(SAMPLES - 1));
    assign pipe_empty = !s1_vld_reg && !s2_vld_reg;
    assign div_done   = (div_cnt_reg == CNT_W'(Q_W - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign bin_last   = (PTS_W'(k_reg) == job_reg.points - PTS_W'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    state_next = B_MAC;
                end
            end
            B_MAC: begin
                if (n_last) begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN: begin
                if (pipe_empty) begin
                    state_next = job_reg.inverse ? B_DIV : B_PUT;
                end
            end
            B_DIV: begin
                if (div_done) begin
                    state_next = B_PUT;
                end
            end
            B_PUT: begin
                if (out_free) begin
                    state_next = bin_last ? B_IDLE : B_MAC;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        job_pop    = 1'b0;
        mac_issue  = 1'b0;
        round_load = 1'b0;
        div_step   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            B_IDLE:  job_pop    = job_valid;
            B_MAC:   mac_issue  = 1'b1;
            B_DRAIN: round_load = pipe_empty;
            B_DIV:   div_step   = 1'b1;
            B_PUT:   out_load   = out_free;
            default: job_pop    = 1'b0;
        endcase
    end

    assign rel.valid = out_load && bin_last;
    assign rel.bank  = job_reg.bank;

    assign m_sum  = {1'b0, m_reg} + {1'b0, k_reg};
    assign m_next = (m_sum >= job_reg.points) ? BIN_W'(m_sum - job_reg.points)
                                              : m_sum[BIN_W-1:0];

    assign half = job_reg.inverse ? (T_W'(job_reg.points) <<< (Q_SHIFT - 1))
                                  : (T_W'(1) <<< (Q_SHIFT - 1));
    assign t_r  = T_W'(acc_r_reg) + half;
    assign t_i  = T_W'(acc_i_reg) + half;
    assign q1_r = t_r[T_W-1:Q_SHIFT];
    assign q1_i = t_i[T_W-1:Q_SHIFT];

    assign r_r  = {rem_r_reg, qr_reg[Q_W-1]};
    assign r_i  = {rem_i_reg, qi_reg[Q_W-1]};
    assign ge_r = (r_r >= job_reg.points);
    assign ge_i = (r_i >= job_reg.points);

    assign v_r = neg_r_reg ? ~qr_reg : qr_reg;
    assign v_i = neg_i_reg ? ~qi_reg : qi_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[{job_reg.bank, n_reg}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            s1_vld_reg <= mac_issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job;
            k_reg   <= '0;
            n_reg   <= '0;
            m_reg   <= '0;
        end else if (mac_issue) begin
            n_reg <= n_reg + NW'(1);
            m_reg <= m_next;
        end else if (out_load && !bin_last) begin
            k_reg <= k_reg + BIN_W'(1);
            n_reg <= '0;
            m_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_issue) begin
            tw_c_reg <= COS_TAB[job_reg.points][m_reg];
            tw_s_reg <= SIN_TAB[job_reg.points][m_reg];
        end
        prod_c_reg <= rd_data_reg * tw_c_reg;
        prod_s_reg <= rd_data_reg * tw_s_reg;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE || round_load) begin
            acc_r_reg <= '0;
            acc_i_reg <= '0;
        end else if (s2_vld_reg) begin
            acc_r_reg <= acc_r_reg + ACC_W'(prod_c_reg);
            if (job_reg.inverse) begin
                acc_i_reg <= acc_i_reg + ACC_W'(prod_s_reg);
            end else begin
                acc_i_reg <= acc_i_reg - ACC_W'(prod_s_reg);
            end
        end
    end

    // A negative quotient is floored as the complement of the quotient of
    // the complemented dividend, so the divider only sees magnitudes.
    always_ff @(posedge aclk) begin
        if (round_load) begin
            neg_r_reg   <= job_reg.inverse && q1_r[Q_W-1];
            neg_i_reg   <= job_reg.inverse && q1_i[Q_W-1];
            qr_reg      <= (job_reg.inverse && q1_r[Q_W-1]) ? ~q1_r : q1_r;
            qi_reg      <= (job_reg.inverse && q1_i[Q_W-1]) ? ~q1_i : q1_i;
            rem_r_reg   <= '0;
            rem_i_reg   <= '0;
            div_cnt_reg <= '0;
        end else if (div_step) begin
            qr_reg      <= {qr_reg[Q_W-2:0], ge_r};
            qi_reg      <= {qi_reg[Q_W-2:0], ge_i};
            rem_r_reg   <= ge_r ? 3'(r_r - job_reg.points) : r_r[2:0];
            rem_i_reg   <= ge_i ? 3'(r_i - job_reg.points) : r_i[2:0];
            div_cnt_reg <= div_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_bin_reg       <= k_reg;
            m_real_part_reg <= saturate(v_r);
            m_imag_part_reg <= saturate(v_i);
            m_last_reg      <= bin_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin       = m_bin_reg;
    assign m_real_part = m_real_part_reg;
    assign m_imag_part = m_imag_part_reg;
    assign m_last      = m_last_reg;

    a_twiddle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_MAC |-> PTS_W'(m_reg) < job_reg.points)
        else $error("twiddle index not reduced below point count");

    a_div_inverse_only: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_DIV |-> job_reg.inverse)
        else $error("divider running in forward mode");

endmodule

// ----- tb/tb_real_input_dft_idft_unit.sv -----
// ----------------------------------------------------------------------------
// tb_real_input_dft_idft_unit
// Self-checking testbench for the real-input DFT/IDFT unit. Blocks of eight
// samples are streamed in, each bin word that comes out is compared with an
// in-bench Q1.14 prediction, and the points and inverse registers are swept
// between blocks (inverse once mid-block) under several tx/rx idle patterns.
// ----------------------------------------------------------------------------
module tb_real_input_dft_idft_unit import rdft_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SAMPLES  = 8;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT  = 2000;

    localparam int COS_Q14 [0:8][0:7] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{16384, 0, 0, 0, 0, 0, 0, 0},
        '{16384, -16384, 0, 0, 0, 0, 0, 0},
        '{16384, -8192, -8192, 0, 0, 0, 0, 0},
        '{16384, 0, -16384, 0, 0, 0, 0, 0},
        '{16384, 5063, -13255, -13255, 5063, 0, 0, 0},
        '{16384, 8192, -8192, -16384, -8192, 8192, 0, 0},
        '{16384, 10215, -3646, -14761, -14761, -3646, 10215, 0},
        '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585}
    };

    localparam int SIN_Q14 [0:8][0:7] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 14189, -14189, 0, 0, 0, 0, 0},
        '{0, 16384, 0, -16384, 0, 0, 0, 0},
        '{0, 15582, 9630, -9630, -15582, 0, 0, 0},
        '{0, 14189, 14189, 0, -14189, -14189, 0, 0},
        '{0, 12810, 15973, 7109, -7109, -15973, -12810, 0},
        '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585}
    };

    typedef struct {
        logic [BIN_W-1:0]        bin;
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    last;
    } bin_word_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_index_t                 cfg_index = CFG_POINTS;
    logic [PTS_W-1:0]           cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [BIN_W-1:0]           m_bin;
    logic signed [OUT_W-1:0]    m_real_part;
    logic signed [OUT_W-1:0]    m_imag_part;
    logic                       m_last;

    bin_word_t                  expected_bins[$];
    logic signed [SAMPLE_W-1:0] held_samples[NUM_SAMPLES];
    int                         held_count = 0;
    logic [PTS_W-1:0]           cur_points = 4'd8;
    logic                       cur_inverse = 1'b0;
    int                         err_count = 0;
    int                         tx_idle_pct = 0;
    int                         rx_idle_pct = 0;
    int                         stall_cycles = 0;

    real_input_dft_idft_unit #(
        .SAMPLES(NUM_SAMPLES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample(s_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_bin(m_bin),
        .m_real_part(m_real_part),
        .m_imag_part(m_imag_part),
        .m_last(m_last)
    );

    always #10 aclk = ~aclk;

    function automatic longint round_half_up(longint acc, longint d);
        longint t;
        t = acc + d / 2;
        if (t >= 0) begin
            return t / d;
        end
        return -((-t + d - 1) / d);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end
        if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

    task automatic predict_bins(logic signed [SAMPLE_W-1:0] x);
        int        p;
        longint    d;
        longint    acc_r;
        longint    acc_i;
        int        m;
        bin_word_t w;
        held_samples[held_count] = x;
        held_count++;
        if (held_count < NUM_SAMPLES) begin
            return;
        end
        held_count = 0;
        p = (cur_points < 1) ? 1 : (cur_points > MAX_POINTS) ? MAX_POINTS : cur_points;
        d = cur_inverse ? 64'sd16384 * p : 64'sd16384;
        for (int k = 0; k < p; k++) begin
            acc_r = 0;
            acc_i = 0;
            for (int n = 0; n < NUM_SAMPLES; n++) begin
                m = (k * n) % p;
                acc_r += longint'(held_samples[n]) * COS_Q14[p][m];
                acc_i += longint'(held_samples[n]) * SIN_Q14[p][m];
            end
            if (!cur_inverse) begin
                acc_i = -acc_i;
            end
            w.bin  = k[BIN_W-1:0];
            w.re   = clamp_out(round_half_up(acc_r, d));
            w.im   = clamp_out(round_half_up(acc_i, d));
            w.last = (k == p - 1);
            expected_bins.push_back(w);
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        bin_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bins.size() == 0) begin
                report_mismatch($sformatf("unexpected word bin %0d", m_bin));
            end else begin
                e = expected_bins.pop_front();
                if (m_bin !== e.bin) begin
                    report_mismatch($sformatf("bin got %0d exp %0d", m_bin, e.bin));
                end
                if (m_real_part !== e.re) begin
                    report_mismatch($sformatf("bin %0d real got %0d exp %0d",
                                              e.bin, m_real_part, e.re));
                end
                if (m_imag_part !== e.im) begin
                    report_mismatch($sformatf("bin %0d imag got %0d exp %0d",
                                              e.bin, m_imag_part, e.im));
                end
                if (m_last !== e.last) begin
                    report_mismatch($sformatf("bin %0d last got %0d exp %0d",
                                              e.bin, m_last, e.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= x;
        do @(posedge aclk); while (!s_ready);
        predict_bins(x);
    endtask

    task automatic wait_bins_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_bins.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        wait_bins_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [PTS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_POINTS) begin
            cur_points = data;
        end else begin
            cur_inverse = data[0];
        end
        @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            send_sample(i[0] ? -16'sd32768 : 16'sd32767);
        end
    endtask

    task automatic test_points_zero();
        wait_idle();
        write_register(CFG_POINTS, 4'd0);
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            send_sample(-16'sd32768);
        end
    endtask

    // The inverse flag changes after half the block is loaded; the whole block
    // must still use the setting in force when its last sample arrives.
    task automatic test_points_over_and_midblock();
        wait_idle();
        write_register(CFG_POINTS, 4'd15);
        for (int i = 0; i < NUM_SAMPLES / 2; i++) begin
            send_sample(16'sd32767);
        end
        wait_idle();
        write_register(CFG_INVERSE, 4'b1111);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
    endtask

    task automatic test_random_sweep(int tx_pct, int rx_pct);
        logic [PTS_W-1:0] pts;
        logic             inv;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int s = 0; s < 5; s++) begin
            pts = (s == 0) ? 4'd1 : (s == 1) ? 4'd8 : PTS_W'($urandom_range(15));
            inv = (s == 0) ? 1'b1 : (s == 1) ? 1'b0 : 1'($urandom_range(1));
            wait_idle();
            write_register(CFG_POINTS, pts);
            write_register(CFG_INVERSE, {3'($urandom_range(7)), inv});
            for (int b = 0; b < 3; b++) begin
                for (int i = 0; i < NUM_SAMPLES; i++) begin
                    send_sample(pick_sample());
                end
                if ($urandom_range(5) == 0) begin
                    wait_bins_drained();
                end
            end
        end
    endtask

    initial begin
        tx_idle_pct = 6;
        rx_idle_pct = 80;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_points_zero();
        test_points_over_and_midblock();
        test_random_sweep(6, 80);
        test_random_sweep(80, 6);
        test_random_sweep(0, 0);
        wait_idle();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/rdft_pkg.sv
hdl/rdft_front.sv
hdl/rdft_job_fifo.sv
hdl/rdft_back.sv
hdl/real_input_dft_idft_unit.sv
tb/tb_real_input_dft_idft_unit.sv
